// ----- hw/rtl/job_sequencing_with_deadlines_top_assert.svh -----
// Assertion macros used by the job sequencing datapath.
`ifndef JOB_SEQUENCING_WITH_DEADLINES_TOP_ASSERT_SVH
`define JOB_SEQUENCING_WITH_DEADLINES_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define JSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsd: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define JSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsd: next-cycle check failed");

`endif

// ----- hw/rtl/jsd_pkg.sv -----
// Types and constants shared by the job sequencing controller and datapath.
package jsd_pkg;

    localparam int PROFIT_W    = 16;
    localparam int DEADLINE_W  = 6;
    localparam int SLOT_OUT_W  = 6;
    localparam int TOTAL_W     = 20;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [DEADLINE_W-1:0] deadline;
        logic [PROFIT_W-1:0]   profit;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLR,
        ST_I_RD,
        ST_I_LAT,
        ST_J_RD,
        ST_J_CMP,
        ST_I_WR,
        ST_K_RD,
        ST_K_LAT,
        ST_S_RD,
        ST_S_CHK,
        ST_PUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR,
        OP_I_RD,
        OP_I_LAT,
        OP_J_RD,
        OP_J_CMP,
        OP_I_WR,
        OP_K_RD,
        OP_K_LAT,
        OP_S_RD,
        OP_S_CHK,
        OP_PUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic sort_skip;
        logic j_last;
        logic i_last;
        logic s_zero;
        logic slot_free;
        logic k_last;
        logic out_free;
    } t_status;

endpackage

// ----- hw/rtl/jsd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module jsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/jsd_ctrl.sv -----
// Sequencer for loading, clearing, sorting, slot search and result output.
module jsd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  jsd_pkg::t_status i_status,
    output jsd_pkg::t_cmd    o_cmd
);

    import jsd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.in_ready = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_in_last) begin
                        n_state = ST_CLR;
                    end
                end
            end
            ST_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_status.clr_last) begin
                    n_state = i_status.sort_skip ? ST_K_RD : ST_I_RD;
                end
            end
            ST_I_RD: begin
                o_cmd.op = OP_I_RD;
                n_state  = ST_I_LAT;
            end
            ST_I_LAT: begin
                o_cmd.op = OP_I_LAT;
                n_state  = ST_J_RD;
            end
            ST_J_RD: begin
                o_cmd.op = OP_J_RD;
                n_state  = ST_J_CMP;
            end
            ST_J_CMP: begin
                o_cmd.op = OP_J_CMP;
                n_state  = i_status.j_last ? ST_I_WR : ST_J_RD;
            end
            ST_I_WR: begin
                o_cmd.op = OP_I_WR;
                n_state  = i_status.i_last ? ST_K_RD : ST_I_RD;
            end
            ST_K_RD: begin
                o_cmd.op = OP_K_RD;
                n_state  = ST_K_LAT;
            end
            ST_K_LAT: begin
                o_cmd.op = OP_K_LAT;
                n_state  = ST_S_RD;
            end
            ST_S_RD: begin
                // Reaching slot zero means no free slot is left for this job.
                if (i_status.s_zero) begin
                    n_state = ST_PUT;
                end else begin
                    o_cmd.op = OP_S_RD;
                    n_state  = ST_S_CHK;
                end
            end
            ST_S_CHK: begin
                o_cmd.op = OP_S_CHK;
                n_state  = i_status.slot_free ? ST_PUT : ST_S_RD;
            end
            ST_PUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_PUT;
                    n_state  = i_status.k_last ? ST_LOAD : ST_K_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

// ----- hw/rtl/jsd_dpath.sv -----
// Job store, slot map, sort and search registers, and the result register.
`include "job_sequencing_with_deadlines_top_assert.svh"

module jsd_dpath #(
    parameter int MAX_JOBS   = 16,
    parameter int SLOT_LIMIT = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  jsd_pkg::t_cmd                       i_cmd,
    input  jsd_pkg::t_job                       i_in_job,
    input  logic                                i_in_last,
    input  logic                                i_out_ready,
    output jsd_pkg::t_status                    o_status,
    output logic                                o_out_valid,
    output logic [jsd_pkg::OUT_TDATA_W-1:0]     o_out_data,
    output logic                                o_out_last
);

    import jsd_pkg::*;

    localparam int CNTW = $clog2(MAX_JOBS + 1);
    localparam int AW   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int SW   = $clog2(SLOT_LIMIT);
    localparam int CW   = (SW > DEADLINE_W) ? SW : DEADLINE_W;

    logic [CNTW-1:0]      r_cnt;
    logic [CNTW-1:0]      r_i;
    logic [CNTW-1:0]      r_j;
    logic [CNTW-1:0]      r_k;
    logic [SW-1:0]        r_s;
    t_job                 r_cur;
    logic [TOTAL_W-1:0]   r_total;
    logic                 r_out_valid;
    logic [PROFIT_W-1:0]  r_out_profit;
    logic [DEADLINE_W-1:0] r_out_deadline;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic [TOTAL_W-1:0]   r_out_total;
    logic                 r_out_final;

    logic                 job_we;
    logic [AW-1:0]        job_waddr;
    t_job                 job_wdata;
    logic [AW-1:0]        job_raddr;
    t_job                 job_rdata;
    logic                 slot_we;
    logic [0:0]           slot_wdata;
    logic [0:0]           slot_rdata;

    logic [CNTW:0]        cnt_ext;
    logic [CW-1:0]        dl_ext;
    logic [CW-1:0]        s_start;
    logic [CW-1:0]        s_ext;
    logic [TOTAL_W:0]     sum;
    logic [TOTAL_W-1:0]   total_next;
    logic                 swap;

    jsd_ram #(.WIDTH(JOB_W), .DEPTH(MAX_JOBS)) u_job_ram (
        .i_clk   (i_clk),
        .i_we    (job_we),
        .i_waddr (job_waddr),
        .i_wdata (job_wdata),
        .i_raddr (job_raddr),
        .o_rdata (job_rdata)
    );

    jsd_ram #(.WIDTH(1), .DEPTH(SLOT_LIMIT)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (r_s),
        .i_wdata (slot_wdata),
        .i_raddr (r_s),
        .o_rdata (slot_rdata)
    );

    assign cnt_ext = {1'b0, r_cnt};
    assign dl_ext  = CW'(job_rdata.deadline);
    assign s_start = (dl_ext > CW'(SLOT_LIMIT - 1)) ? CW'(SLOT_LIMIT - 1) : dl_ext;
    assign s_ext   = CW'(r_s);
    assign swap    = (r_cur.profit < job_rdata.profit);
    assign sum     = {1'b0, r_total} + (TOTAL_W + 1)'(r_cur.profit);
    assign total_next = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];

    always_comb begin
        job_we     = 1'b0;
        job_waddr  = r_cnt[AW-1:0];
        job_wdata  = i_in_job;
        job_raddr  = r_k[AW-1:0];
        slot_we    = 1'b0;
        slot_wdata = 1'b0;
        case (i_cmd.op)
            OP_LOAD: begin
                job_we = (r_cnt < CNTW'(MAX_JOBS));
            end
            OP_CLR: begin
                slot_we = 1'b1;
            end
            OP_I_RD: begin
                job_raddr = r_i[AW-1:0];
            end
            OP_J_RD: begin
                job_raddr = r_j[AW-1:0];
            end
            OP_J_CMP: begin
                job_we    = swap;
                job_waddr = r_j[AW-1:0];
                job_wdata = r_cur;
            end
            OP_I_WR: begin
                job_we    = 1'b1;
                job_waddr = r_i[AW-1:0];
                job_wdata = r_cur;
            end
            OP_S_CHK: begin
                slot_we    = ~slot_rdata[0];
                slot_wdata = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    if (r_cnt < CNTW'(MAX_JOBS)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (i_in_last) begin
                        r_i     <= '0;
                        r_k     <= '0;
                        r_s     <= '0;
                        r_total <= '0;
                    end
                end
                OP_CLR: begin
                    r_s <= r_s + 1'b1;
                end
                OP_I_RD: begin
                    r_j <= r_i + 1'b1;
                end
                OP_I_LAT: begin
                    r_cur <= job_rdata;
                end
                OP_J_CMP: begin
                    if (swap) begin
                        r_cur <= job_rdata;
                    end
                    r_j <= r_j + 1'b1;
                end
                OP_I_WR: begin
                    r_i <= r_i + 1'b1;
                end
                OP_K_LAT: begin
                    r_cur <= job_rdata;
                    r_s   <= s_start[SW-1:0];
                end
                OP_S_CHK: begin
                    if (slot_rdata[0]) begin
                        r_s <= r_s - 1'b1;
                    end
                end
                OP_PUT: begin
                    r_out_valid    <= 1'b1;
                    r_out_profit   <= r_cur.profit;
                    r_out_deadline <= r_cur.deadline;
                    r_out_slot     <= s_ext[SLOT_OUT_W-1:0];
                    r_out_final    <= o_status.k_last;
                    r_out_total    <= (r_s != '0) ? total_next : r_total;
                    if (r_s != '0) begin
                        r_total <= total_next;
                    end
                    r_k <= r_k + 1'b1;
                    if (o_status.k_last) begin
                        r_cnt <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.clr_last  = (r_s == SW'(SLOT_LIMIT - 1));
    assign o_status.sort_skip = (r_cnt <= CNTW'(1));
    assign o_status.j_last    = (({1'b0, r_j} + 1'b1) == cnt_ext);
    assign o_status.i_last    = (({1'b0, r_i} + 2'd2) == cnt_ext);
    assign o_status.s_zero    = (r_s == '0);
    assign o_status.slot_free = ~slot_rdata[0];
    assign o_status.k_last    = (({1'b0, r_k} + 1'b1) == cnt_ext);
    assign o_status.out_free  = ~r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out_total, r_out_slot, r_out_deadline, r_out_profit};
    assign o_out_last  = r_out_final;

    `JSD_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNTW'(MAX_JOBS))
    `JSD_ASSERT_NEXT(a_reject_keeps_total, i_clk, i_rst_n, (i_cmd.op == OP_PUT) && (r_s == '0), r_out_total == $past(r_total))
    `JSD_ASSERT_NEXT(a_total_monotonic, i_clk, i_rst_n, i_cmd.op != OP_LOAD, r_total >= $past(r_total))
    `JSD_ASSERT_NEXT(a_final_clears_batch, i_clk, i_rst_n, (i_cmd.op == OP_PUT) && o_status.k_last, (r_cnt == '0) && r_out_final)

endmodule

// ----- hw/rtl/job_sequencing_with_deadlines_top.sv -----
// Top level of the greedy job sequencing with deadlines block.
//
//  Channel  Direction  Handshake                        Payload
//  -------  ---------  -------------------------------  ------------------------------
//  s_axis   in         i_s_axis_tvalid/o_s_axis_tready  profit, deadline; tlast ends batch
//  m_axis   out        o_m_axis_tvalid/i_m_axis_tready  profit, deadline, slot, total
//
// Loading takes one cycle per job transfer; jobs beyond MAX_JOBS are dropped.
// After the last job, a clearing pass sweeps the slot map RAM, then the exchange sort orders
// the n stored jobs by profit, highest first. Each result reads its job and probes the slot
// map down from its deadline, capped at SLOT_LIMIT-1, until it finds a free slot or reaches
// slot zero. Reset is synchronous and active low and clears the sequencer, the job count,
// the total and the output valid flag; a stalled output holds its register.
module job_sequencing_with_deadlines_top #(
    parameter int MAX_JOBS   = 16,
    parameter int SLOT_LIMIT = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [15:0] job_profit, [21:16] job_deadline, [23:22] zero fill
    input  logic [jsd_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [15:0] out_profit, [21:16] out_deadline, [27:22] assigned_slot,
    // [47:28] running_total
    output logic [jsd_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);

    import jsd_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_job    in_job;

    // The job fields sit in the low bits of the input word, profit first.
    assign in_job = i_s_axis_tdata[JOB_W-1:0];
    assign o_s_axis_tready = cmd.in_ready;

    jsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath owns the job RAM, the slot map RAM and the result register.
    jsd_dpath #(
        .MAX_JOBS   (MAX_JOBS),
        .SLOT_LIMIT (SLOT_LIMIT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_job    (in_job),
        .i_in_last   (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_status    (status),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule
